[hdl/drm_pkg.sv]
// Package with ring sizes, descriptor bit constants and shared types of the descriptor ring manager.
`default_nettype none

package drm_pkg;

  // Ring sizes and receive buffer size.
  localparam int unsigned TX_DEPTH  = 8;
  localparam int unsigned RX_DEPTH  = 16;
  localparam int unsigned BUF_BYTES = 2048;

  localparam int unsigned TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned OUTC_W = 4;

  // Descriptor status bits.
  localparam logic [WORD_W-1:0] BD_READY   = 16'h8000;
  localparam logic [WORD_W-1:0] BD_WRAP    = 16'h2000;
  localparam logic [WORD_W-1:0] BD_LAST    = 16'h0800;
  localparam logic [WORD_W-1:0] BD_FIRST   = 16'h0400;
  localparam logic [WORD_W-1:0] BD_CRC     = 16'h0400;
  localparam logic [WORD_W-1:0] BD_ERRMASK = 16'h003f;
  localparam logic [WORD_W-1:0] BD_CRCERR  = 16'h0004;

  localparam logic [WORD_W-1:0] MIN_FRAME  = 16'd60;
  localparam logic [WORD_W-1:0] MIN_RX_LEN = 16'd18;
  localparam logic [WORD_W-1:0] FCS_BYTES  = 16'd4;
  localparam logic [WORD_W-1:0] BUF_LEN    = WORD_W'(BUF_BYTES);

  typedef enum logic [FUNC_W-1:0] {
    FN_TX_REQ = 2'd0,
    FN_REAP   = 2'd1,
    FN_RX_CHK = 2'd2,
    FN_RSVD   = 2'd3
  } func_t;

  typedef enum logic [OUTC_W-1:0] {
    OC_QUEUED    = 4'd0,
    OC_OVERSIZE  = 4'd1,
    OC_BUSY      = 4'd2,
    OC_REAPED    = 4'd3,
    OC_PENDING   = 4'd4,
    OC_TX_EMPTY  = 4'd5,
    OC_RX_EMPTY  = 4'd6,
    OC_DELIVERED = 4'd7,
    OC_RX_ERROR  = 4'd8
  } outcome_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic execute;
  } drm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
  } drm_sts_t;

endpackage

`default_nettype wire

[hdl/drm_if.sv]
// Valid/ready channel interfaces for request items and result items.
`default_nettype none

interface drm_in_if;
  import drm_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [WORD_W-1:0]   frame_len;
  logic [WORD_W-1:0]   desc_status;
  logic [WORD_W-1:0]   desc_length;

  modport source (output valid, func, frame_len, desc_status, desc_length, input ready);
  modport sink   (input valid, func, frame_len, desc_status, desc_length, output ready);
endinterface

interface drm_out_if;
  import drm_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUTC_W-1:0]   outcome;
  logic [IDX_W-1:0]    desc_index;
  logic [WORD_W-1:0]   status_write;
  logic [WORD_W-1:0]   length_write;
  logic                crc_error;
  logic                queue_stopped;
  logic                kick_dma;
  logic [IDX_W-1:0]    tx_in_use;

  modport source (output valid, outcome, desc_index, status_write, length_write, crc_error,
                  queue_stopped, kick_dma, tx_in_use, input ready);
  modport sink   (input valid, outcome, desc_index, status_write, length_write, crc_error,
                  queue_stopped, kick_dma, tx_in_use, output ready);
endinterface

`default_nettype wire

[hdl/descriptor_ring_manager.sv]
// Top level of the descriptor ring manager: controller plus datapath on valid/ready channels.
// An accepted item is captured, then executes once the result register is free and loads its
// result into the result register; a result still waiting delays execution.
// A new item is taken only after the last one has executed, so capture and execute alternate;
// a result waiting downstream holds execution of the following item, not its acceptance.
// Reset: synchronous active-low rst_n clears the ring pointers, used count and stop flag.
`default_nettype none

module descriptor_ring_manager
  import drm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  drm_in_if.sink      in_ch,
  drm_out_if.source   out_ch
);

  // Command and status link between the sequencing controller and the datapath.
  drm_cmd_t cmd;
  drm_sts_t sts;

  // The controller owns the handshake: it takes an item into the capture registers,
  // then runs it through the datapath once the result register can accept a new result.
  // Items with the reserved function code update nothing and produce no result item.
  drm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the transmit and receive ring state and the registered result fields.
  drm_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_frame_len      (in_ch.frame_len),
    .in_desc_status    (in_ch.desc_status),
    .in_desc_length    (in_ch.desc_length),
    .out_outcome       (out_ch.outcome),
    .out_desc_index    (out_ch.desc_index),
    .out_status_write  (out_ch.status_write),
    .out_length_write  (out_ch.length_write),
    .out_crc_error     (out_ch.crc_error),
    .out_queue_stopped (out_ch.queue_stopped),
    .out_kick_dma      (out_ch.kick_dma),
    .out_tx_in_use     (out_ch.tx_in_use)
  );

endmodule

`default_nettype wire

[hdl/drm_ctrl.sv]
// Controller state machine that sequences item capture, execution and result handoff.
`default_nettype none

module drm_ctrl
  import drm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire drm_sts_t sts,
  output drm_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free     = !out_valid_r || out_ready;
  assign cmd.load_item = in_valid && in_ready_r;
  assign cmd.execute   = (state_r == ST_EXEC) && slot_free;
  assign in_ready      = in_ready_r;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.load_item) begin
            state_r    <= ST_EXEC;
            in_ready_r <= 1'b0;
          end
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (cmd.execute) begin
            state_r     <= ST_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= sts.has_result;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == ST_IDLE))
    else $error("input ready outside idle state");

  a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_ready) |=> (state_r == ST_EXEC && out_valid_r))
    else $error("execution did not wait for a blocked result");

  a_item_executes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> (state_r == ST_EXEC))
    else $error("accepted item was not scheduled for execution");
`endif

endmodule

`default_nettype wire

[hdl/drm_datapath.sv]
// Datapath holding ring pointers, item capture registers and the result register.
`default_nettype none

module drm_datapath
  import drm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire drm_cmd_t          cmd,
  output drm_sts_t               sts,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [WORD_W-1:0] in_frame_len,
  input  wire logic [WORD_W-1:0] in_desc_status,
  input  wire logic [WORD_W-1:0] in_desc_length,
  output logic [OUTC_W-1:0]      out_outcome,
  output logic [IDX_W-1:0]       out_desc_index,
  output logic [WORD_W-1:0]      out_status_write,
  output logic [WORD_W-1:0]      out_length_write,
  output logic                   out_crc_error,
  output logic                   out_queue_stopped,
  output logic                   out_kick_dma,
  output logic [IDX_W-1:0]       out_tx_in_use
);

  localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);
  localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
  localparam logic [TX_CNT_W-1:0] TX_FULL = TX_CNT_W'(TX_DEPTH);

  // Captured item.
  func_t             func_r;
  logic [WORD_W-1:0] frame_len_r;
  logic [WORD_W-1:0] desc_status_r;
  logic [WORD_W-1:0] desc_length_r;

  // Ring state.
  logic [TX_PTR_W-1:0] tx_head_r, tx_head_nxt;
  logic [TX_PTR_W-1:0] tx_tail_r, tx_tail_nxt;
  logic [TX_CNT_W-1:0] tx_used_r, tx_used_nxt;
  logic [RX_PTR_W-1:0] rx_slot_r, rx_slot_nxt;
  logic                stopped_r, stopped_nxt;

  // Result register.
  logic [OUTC_W-1:0] outcome_r, outcome_nxt;
  logic [IDX_W-1:0]  index_r, index_nxt;
  logic [WORD_W-1:0] status_wr_r, status_wr_nxt;
  logic [WORD_W-1:0] length_wr_r, length_wr_nxt;
  logic              crc_r, crc_nxt;
  logic              kick_r, kick_nxt;
  logic              stopped_out_r;
  logic [IDX_W-1:0]  in_use_r;

  logic [WORD_W-1:0] pad_len;
  logic              rx_bad;

  assign sts.has_result = (func_r != FN_RSVD);

  assign pad_len = (frame_len_r < MIN_FRAME) ? MIN_FRAME : frame_len_r;
  assign rx_bad  = ((desc_status_r & BD_ERRMASK) != '0)
                || ((desc_status_r & (BD_FIRST | BD_LAST)) != (BD_FIRST | BD_LAST))
                || (desc_length_r < MIN_RX_LEN) || (desc_length_r > BUF_LEN);

  always_comb begin
    tx_head_nxt   = tx_head_r;
    tx_tail_nxt   = tx_tail_r;
    tx_used_nxt   = tx_used_r;
    rx_slot_nxt   = rx_slot_r;
    stopped_nxt   = stopped_r;
    outcome_nxt   = OC_QUEUED;
    index_nxt     = '0;
    status_wr_nxt = '0;
    length_wr_nxt = '0;
    crc_nxt       = 1'b0;
    kick_nxt      = 1'b0;
    case (func_r)
      FN_TX_REQ: begin
        index_nxt = IDX_W'(tx_head_r);
        if (pad_len > BUF_LEN) begin
          outcome_nxt = OC_OVERSIZE;
        end else if (tx_used_r >= TX_FULL) begin
          stopped_nxt = 1'b1;
          outcome_nxt = OC_BUSY;
        end else begin
          status_wr_nxt = BD_READY | BD_LAST | BD_CRC
                        | ((tx_head_r == TX_LAST) ? BD_WRAP : '0);
          length_wr_nxt = pad_len;
          kick_nxt      = 1'b1;
          tx_head_nxt   = (tx_head_r == TX_LAST) ? '0 : TX_PTR_W'(tx_head_r + 1'b1);
          tx_used_nxt   = TX_CNT_W'(tx_used_r + 1'b1);
          if (tx_used_nxt == TX_FULL) begin
            stopped_nxt = 1'b1;
          end
          outcome_nxt = OC_QUEUED;
        end
      end
      FN_REAP: begin
        index_nxt = IDX_W'(tx_tail_r);
        if (tx_used_r == '0) begin
          outcome_nxt = OC_TX_EMPTY;
        end else if ((desc_status_r & BD_READY) != '0) begin
          outcome_nxt = OC_PENDING;
        end else begin
          tx_tail_nxt = (tx_tail_r == TX_LAST) ? '0 : TX_PTR_W'(tx_tail_r + 1'b1);
          tx_used_nxt = TX_CNT_W'(tx_used_r - 1'b1);
          outcome_nxt = OC_REAPED;
        end
        // Wake the queue once the ring has room again.
        if (stopped_r && (tx_used_nxt < TX_FULL)) begin
          stopped_nxt = 1'b0;
        end
      end
      FN_RX_CHK: begin
        index_nxt = IDX_W'(rx_slot_r);
        if ((desc_status_r & BD_READY) != '0) begin
          outcome_nxt = OC_RX_EMPTY;
        end else begin
          if (rx_bad) begin
            outcome_nxt = OC_RX_ERROR;
            crc_nxt     = ((desc_status_r & BD_CRCERR) != '0);
          end else begin
            outcome_nxt   = OC_DELIVERED;
            length_wr_nxt = desc_length_r - FCS_BYTES;
          end
          status_wr_nxt = BD_READY | ((rx_slot_r == RX_LAST) ? BD_WRAP : '0);
          kick_nxt      = 1'b1;
          rx_slot_nxt   = (rx_slot_r == RX_LAST) ? '0 : RX_PTR_W'(rx_slot_r + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r        <= func_t'(in_func);
      frame_len_r   <= in_frame_len;
      desc_status_r <= in_desc_status;
      desc_length_r <= in_desc_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= '0;
      tx_tail_r <= '0;
      tx_used_r <= '0;
      rx_slot_r <= '0;
      stopped_r <= 1'b0;
    end else if (cmd.execute) begin
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      tx_used_r <= tx_used_nxt;
      rx_slot_r <= rx_slot_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && sts.has_result) begin
      outcome_r     <= outcome_nxt;
      index_r       <= index_nxt;
      status_wr_r   <= status_wr_nxt;
      length_wr_r   <= length_wr_nxt;
      crc_r         <= crc_nxt;
      kick_r        <= kick_nxt;
      stopped_out_r <= stopped_nxt;
      in_use_r      <= IDX_W'(tx_used_nxt);
    end
  end

  assign out_outcome       = outcome_r;
  assign out_desc_index    = index_r;
  assign out_status_write  = status_wr_r;
  assign out_length_write  = length_wr_r;
  assign out_crc_error     = crc_r;
  assign out_queue_stopped = stopped_out_r;
  assign out_kick_dma      = kick_r;
  assign out_tx_in_use     = in_use_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_used_r <= TX_FULL)
    else $error("transmit used count beyond ring depth");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_used_r == '0 || tx_used_r == TX_FULL) |-> (tx_head_r == tx_tail_r))
    else $error("head and tail disagree with used count");

  a_stop_full: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (tx_used_r == TX_FULL))
    else $error("queue stopped while ring has room");
`endif

endmodule

`default_nettype wire

[sim/descriptor_ring_manager_tb.sv]
// Self-checking testbench for the descriptor ring manager: directed and random item traffic.
module descriptor_ring_manager_tb;
  import drm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 445;

  // One request item as the sender offers it.
  typedef struct packed {
    func_t             func;
    logic [WORD_W-1:0] frame_len;
    logic [WORD_W-1:0] desc_status;
    logic [WORD_W-1:0] desc_length;
  } request_t;

  // One result item as the block should present it.
  typedef struct packed {
    outcome_t          outcome;
    logic [IDX_W-1:0]  desc_index;
    logic [WORD_W-1:0] status_write;
    logic [WORD_W-1:0] length_write;
    logic              crc_error;
    logic              queue_stopped;
    logic              kick_dma;
    logic [IDX_W-1:0]  tx_in_use;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  drm_in_if  in_ch ();
  drm_out_if out_ch ();

  descriptor_ring_manager dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Results predicted for accepted items, oldest first.
  result_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle percentages for the two sides, and a long result stall counted down
  // by the receiving process.
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 82;
  int unsigned stall_hold = 0;

  // The testbench's own copy of the ring state.
  logic [TX_PTR_W-1:0] ring_head;
  logic [TX_PTR_W-1:0] ring_tail;
  logic [TX_CNT_W-1:0] ring_used;
  logic [RX_PTR_W-1:0] rx_cur;
  logic                queue_stop;

  // Works out the result of one accepted item and updates the ring state.
  // A reserved function code leaves the state alone and produces no result.
  function automatic void predict_ring_result(input request_t req);
    result_t           res;
    logic [WORD_W-1:0] padded;
    logic              bad;
    res = '0;
    case (req.func)
      FN_TX_REQ: begin
        padded = (req.frame_len < MIN_FRAME) ? MIN_FRAME : req.frame_len;
        res.desc_index = IDX_W'(ring_head);
        if (padded > BUF_LEN) begin
          res.outcome = OC_OVERSIZE;
        end else if (ring_used >= TX_DEPTH) begin
          queue_stop = 1'b1;
          res.outcome = OC_BUSY;
        end else begin
          res.status_write = BD_READY | BD_LAST | BD_CRC |
                             ((ring_head == TX_DEPTH - 1) ? BD_WRAP : '0);
          res.length_write = padded;
          res.kick_dma = 1'b1;
          ring_head = (ring_head == TX_DEPTH - 1) ? '0 : ring_head + 1'b1;
          ring_used = ring_used + 1'b1;
          if (ring_used == TX_DEPTH) queue_stop = 1'b1;
          res.outcome = OC_QUEUED;
        end
      end
      FN_REAP: begin
        res.desc_index = IDX_W'(ring_tail);
        if (ring_used == 0) begin
          res.outcome = OC_TX_EMPTY;
        end else if ((req.desc_status & BD_READY) != 0) begin
          res.outcome = OC_PENDING;
        end else begin
          ring_tail = (ring_tail == TX_DEPTH - 1) ? '0 : ring_tail + 1'b1;
          ring_used = ring_used - 1'b1;
          res.outcome = OC_REAPED;
        end
        // The queue wakes as soon as the ring has room again.
        if (queue_stop && ring_used < TX_DEPTH) queue_stop = 1'b0;
      end
      FN_RX_CHK: begin
        res.desc_index = IDX_W'(rx_cur);
        if ((req.desc_status & BD_READY) != 0) begin
          res.outcome = OC_RX_EMPTY;
        end else begin
          bad = ((req.desc_status & BD_ERRMASK) != 0) ||
                ((req.desc_status & (BD_FIRST | BD_LAST)) != (BD_FIRST | BD_LAST)) ||
                (req.desc_length < MIN_RX_LEN) || (req.desc_length > BUF_LEN);
          if (bad) begin
            res.outcome = OC_RX_ERROR;
            res.crc_error = ((req.desc_status & BD_CRCERR) != 0);
          end else begin
            res.outcome = OC_DELIVERED;
            res.length_write = req.desc_length - FCS_BYTES;
          end
          res.status_write = BD_READY | ((rx_cur == RX_DEPTH - 1) ? BD_WRAP : '0);
          res.kick_dma = 1'b1;
          rx_cur = (rx_cur == RX_DEPTH - 1) ? '0 : rx_cur + 1'b1;
        end
      end
      default: return;
    endcase
    res.queue_stopped = queue_stop;
    res.tx_in_use = IDX_W'(ring_used);
    expected_results.push_back(res);
  endfunction

  // Offers one item from a falling edge, with random idle cycles first, and
  // returns at the rising edge that accepts it. Valid stays high until the
  // next falling edge, where the next call or a drain decides its value.
  task automatic send_item(input request_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= req.func;
    in_ch.frame_len   <= req.frame_len;
    in_ch.desc_status <= req.desc_status;
    in_ch.desc_length <= req.desc_length;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_ring_result(req);
  endtask

  task automatic send_fields(input func_t fn, input logic [WORD_W-1:0] flen,
                             input logic [WORD_W-1:0] st, input logic [WORD_W-1:0] dlen);
    request_t req;
    req = '{func: fn, frame_len: flen, desc_status: st, desc_length: dlen};
    send_item(req);
  endtask

  // Stops offering and waits until every predicted result has come back,
  // then waits on to catch any extra result.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random request, biased toward well-formed traffic that keeps the
  // transmit ring cycling between empty and full.
  function automatic request_t random_request();
    request_t    req;
    int unsigned pick;
    req.frame_len   = WORD_W'($urandom);
    req.desc_status = WORD_W'($urandom);
    req.desc_length = WORD_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      req.func = FN_TX_REQ;
      case ($urandom_range(9))
        0, 1:    ;
        2:       req.frame_len = WORD_W'($urandom_range(70, 50));
        3:       req.frame_len = WORD_W'($urandom_range(BUF_BYTES + 12, BUF_BYTES - 12));
        default: req.frame_len = WORD_W'($urandom_range(BUF_BYTES));
      endcase
    end else if (pick < 75) begin
      req.func = FN_REAP;
      if ($urandom_range(3) != 0) req.desc_status = req.desc_status & ~BD_READY;
    end else if (pick < 95) begin
      req.func = FN_RX_CHK;
      case ($urandom_range(9))
        0, 1, 2: ;
        3:       req.desc_status = req.desc_status | BD_READY;
        4: begin
          req.desc_status = (req.desc_status & 16'h7fc0) | BD_FIRST | BD_LAST;
          req.desc_length = WORD_W'($urandom_range(24, 12));
        end
        5: begin
          req.desc_status = (req.desc_status & 16'h7fc0) | BD_FIRST | BD_LAST;
          req.desc_length = WORD_W'($urandom_range(BUF_BYTES + 6, BUF_BYTES - 6));
        end
        default: begin
          req.desc_status = (req.desc_status & 16'h7fc0) | BD_FIRST | BD_LAST;
          req.desc_length = WORD_W'($urandom_range(BUF_BYTES, MIN_RX_LEN));
        end
      endcase
    end else begin
      req.func = FN_RSVD;
    end
    return req;
  endfunction

  // Sends the given number of result-producing random items; reserved codes
  // are mixed in but not counted.
  task automatic send_random_items(input int unsigned count);
    request_t    req;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      req = random_request();
      send_item(req);
      if (req.func != FN_RSVD) sent++;
    end
  endtask

  // Transmit ring: empty reap, padding, oversize drops, filling to busy,
  // pending and retired reaps, and a reserved code that must be ignored.
  task automatic test_transmit_ring();
    send_fields(FN_REAP,   16'd0,     16'h0000, 16'd0);
    send_fields(FN_TX_REQ, 16'd0,     16'hffff, 16'hffff);
    send_fields(FN_TX_REQ, 16'd59,    16'h0000, 16'h0000);
    send_fields(FN_TX_REQ, 16'd60,    16'h0000, 16'h0000);
    send_fields(FN_TX_REQ, 16'd2048,  16'h0000, 16'h0000);
    send_fields(FN_TX_REQ, 16'd2049,  16'h0000, 16'h0000);
    send_fields(FN_TX_REQ, 16'hffff,  16'h0000, 16'h0000);
    repeat (4) send_fields(FN_TX_REQ, 16'd1500, 16'h0000, 16'h0000);
    // Ring is full now: the next request is refused and a ready tail stays.
    send_fields(FN_TX_REQ, 16'd100,   16'h0000, 16'h0000);
    send_fields(FN_REAP,   16'd0,     16'h8000, 16'h0000);
    send_fields(FN_REAP,   16'hffff,  16'h7fff, 16'hffff);
    send_fields(FN_RSVD,   16'hffff,  16'hffff, 16'hffff);
    drain_results();
  endtask

  // Receive ring: an empty descriptor, good frames at both length limits,
  // lengths just outside them, a CRC error, a missing first flag and a
  // set error bit.
  task automatic test_receive_ring();
    send_fields(FN_RX_CHK, 16'd0, 16'h8c00, 16'd64);
    send_fields(FN_RX_CHK, 16'd0, 16'h0c00, 16'd18);
    send_fields(FN_RX_CHK, 16'd0, 16'h0c00, 16'd2048);
    send_fields(FN_RX_CHK, 16'd0, 16'h0c00, 16'd17);
    send_fields(FN_RX_CHK, 16'd0, 16'h0c00, 16'd2049);
    send_fields(FN_RX_CHK, 16'd0, 16'h0c04, 16'd100);
    send_fields(FN_RX_CHK, 16'd0, 16'h0800, 16'd100);
    send_fields(FN_RX_CHK, 16'd0, 16'h0c20, 16'd100);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block fills up and stops accepting items.
  task automatic test_result_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_hold = 80;
    send_random_items(24);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_random_items(RANDOM_ITEMS);
    drain_results();
  endtask

  // Receiver: random back-pressure, or a forced stall while stall_hold runs.
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      out_ch.ready <= 1'b0;
      stall_hold = stall_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares one field and reports a mismatch.
  function automatic void compare_field(input string name, input logic [WORD_W-1:0] exp_val,
                                        input logic [WORD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
    end
  endfunction

  // Checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none actual outcome %h index %h",
                 $time, out_ch.outcome, out_ch.desc_index);
      end else begin
        exp_res = expected_results.pop_front();
        compare_field("outcome",       WORD_W'(exp_res.outcome),       WORD_W'(out_ch.outcome));
        compare_field("desc_index",    WORD_W'(exp_res.desc_index),    WORD_W'(out_ch.desc_index));
        compare_field("status_write",  exp_res.status_write,           out_ch.status_write);
        compare_field("length_write",  exp_res.length_write,           out_ch.length_write);
        compare_field("crc_error",     WORD_W'(exp_res.crc_error),     WORD_W'(out_ch.crc_error));
        compare_field("queue_stopped", WORD_W'(exp_res.queue_stopped),
                      WORD_W'(out_ch.queue_stopped));
        compare_field("kick_dma",      WORD_W'(exp_res.kick_dma),      WORD_W'(out_ch.kick_dma));
        compare_field("tx_in_use",     WORD_W'(exp_res.tx_in_use),     WORD_W'(out_ch.tx_in_use));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_TX_REQ;
    in_ch.frame_len   = '0;
    in_ch.desc_status = '0;
    in_ch.desc_length = '0;
    out_ch.ready      = 1'b0;
    ring_head  = '0;
    ring_tail  = '0;
    ring_used  = '0;
    rx_cur     = '0;
    queue_stop = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_transmit_ring();
    test_receive_ring();
    test_result_stall();
    test_random_traffic(31, 82);
    test_random_traffic(82, 31);
    test_random_traffic(0, 0);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hdl/drm_pkg.sv
hdl/drm_if.sv
hdl/drm_ctrl.sv
hdl/drm_datapath.sv
hdl/descriptor_ring_manager.sv
sim/descriptor_ring_manager_tb.sv
